// ===== hdl/hlfs_pkg.sv =====
// types, codes and hash constants for the heavy/light flow sketch insert block
// no dependencies
package hlfs_pkg;

  typedef struct packed {
    logic [31:0] flow_id;
    logic [31:0] random_word;
  } in_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [11:0] bucket_index;
    logic [1:0]  slot_index;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_FIN, ST_DIV, ST_READ, ST_UPDATE
  } state_t;

  localparam logic [2:0] OC_HEAVY_HIT   = 3'd0;
  localparam logic [2:0] OC_HEAVY_CLAIM = 3'd1;
  localparam logic [2:0] OC_LIGHT_COUNT = 3'd2;
  localparam logic [2:0] OC_LIGHT_SKIP  = 3'd3;
  localparam logic [2:0] OC_PROMOTED    = 3'd4;

  localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2   = 32'h1b873593;
  localparam logic [31:0] MM_ADD  = 32'he6546b64;
  localparam logic [31:0] MM_F1   = 32'h85ebca6b;
  localparam logic [31:0] MM_F2   = 32'hc2b2ae35;
  localparam logic [31:0] MM_SEED = 32'd1;
  localparam logic [31:0] MM_LEN  = 32'd4;

  localparam logic [12:0] BUCKET_COUNT_RESET = 13'd4096;
  localparam logic [7:0]  CNT_MAX     = 8'd255;
  localparam logic [7:0]  CNT_PROMOTE = 8'd32;

endpackage

// ===== hdl/heavy_light_flow_sketch_insert_top.sv =====
// heavy/light flow sketch insert: hash, bucket modulo and bucket memory update
// depends on hlfs_pkg
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one word: flow_id, random_word
//   out channel (out_valid/out_ready/out_data) gives one word per input word:
//     outcome, bucket_index, slot_index
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes bucket_count; always ready,
//     write it only while the block is idle
// timing: one word at a time; after the input is accepted, the item passes
//   through hash states ST_MUL1 to ST_MUL4 (one 32x32 multiply each), a final
//   mix state, the one-bit-per-cycle remainder unit for hash mod bucket_count
//   (clamped to 1..BUCKETS), a memory read state and a read-modify-write state.
//   in_ready comes back the cycle after the write, while the result may still
//   sit in the output register; no new word is taken before the last is written.
// reset: synchronous rst clears control and sets bucket_count to 4096, then a
//   clearing pass zeroes the bucket memory, one entry a cycle, during which
//   in_ready is low
// stall: a result waiting on out_ready holds the next item at its write step
module heavy_light_flow_sketch_insert_top #(
  parameter int BUCKETS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hlfs_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hlfs_pkg::out_t      out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_data
);
  import hlfs_pkg::*;

  localparam int AW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW0 = $clog2(BUCKETS + 1);
  localparam int NW  = (NW0 > 13) ? NW0 : 13;

  state_t state, state_next;

  logic [63:0] mem [BUCKETS];
  logic [63:0] rdata;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0] mem_wdata;

  logic [AW-1:0] clr_addr;
  logic [12:0]   bucket_count;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] bc_ext;
  in_t           item;
  logic [31:0]   h;
  logic [31:0]   dividend;
  logic [NW:0]   rem;
  logic [NW:0]   rem_shift;
  logic [4:0]    div_cnt;

  logic [31:0] k_rot, h_mix, h_pre, h_x13;
  logic [63:0] w_new;
  out_t        res;
  logic        upd_go;

  // hash combinational helpers between multiplies
  always_comb begin
    k_rot = {h[16:0], h[31:17]};
    h_mix = MM_SEED ^ h;
    h_pre = ({h_mix[18:0], h_mix[31:19]} * 32'd5) + MM_ADD;
    h_pre = h_pre ^ MM_LEN;
    h_pre = h_pre ^ {16'd0, h_pre[31:16]};
    h_x13 = h ^ {13'd0, h[31:13]};
  end

  always_comb begin
    bc_ext    = NW'(bucket_count);
    rem_shift = {rem[NW-1:0], dividend[31]};
  end

  // bucket update
  always_comb begin
    logic [7:0] fp, c0, c1, c2, bestc;
    logic [1:0] lcell, best, co;
    logic [3:0] lc;
    logic [2:0] e, co_inc;
    logic       inc;
    fp   = h[7:0];
    lcell = h[1:0];
    c0   = rdata[15:8];
    c1   = rdata[31:24];
    c2   = rdata[47:40];
    w_new = rdata;
    res.bucket_index = rem[11:0];
    res.outcome = OC_HEAVY_HIT;
    res.slot_index = 2'd0;
    lc = rdata[48 + 4*lcell +: 4];
    e  = {1'b0, lc[3:2]};
    co = lc[1:0];
    co_inc = {1'b0, co} + 3'd1;
    inc = (e < 3'd2) || (item.random_word[31:30] == 2'b00);
    best = 2'd0;
    bestc = c0;
    if (c1 < bestc) begin
      best = 2'd1;
      bestc = c1;
    end
    if (c2 < bestc) begin
      best = 2'd2;
    end
    priority if (rdata[7:0] == fp) begin
      w_new[15:8] = (c0 < CNT_MAX) ? c0 + 8'd1 : c0;
    end else if (rdata[7:0] == 8'd0) begin
      w_new[15:0] = {8'd1, fp};
      res.outcome = OC_HEAVY_CLAIM;
    end else if (rdata[23:16] == fp) begin
      w_new[31:24] = (c1 < CNT_MAX) ? c1 + 8'd1 : c1;
      res.slot_index = 2'd1;
    end else if (rdata[23:16] == 8'd0) begin
      w_new[31:16] = {8'd1, fp};
      res.outcome = OC_HEAVY_CLAIM;
      res.slot_index = 2'd1;
    end else if (rdata[39:32] == fp) begin
      w_new[47:40] = (c2 < CNT_MAX) ? c2 + 8'd1 : c2;
      res.slot_index = 2'd2;
    end else if (rdata[39:32] == 8'd0) begin
      w_new[47:32] = {8'd1, fp};
      res.outcome = OC_HEAVY_CLAIM;
      res.slot_index = 2'd2;
    end else begin
      res.slot_index = lcell;
      if (!inc) begin
        res.outcome = OC_LIGHT_SKIP;
      end else begin
        res.outcome = OC_LIGHT_COUNT;
        if (co_inc >= 3'd3) begin
          co_inc = 3'd0;
          e = e + 3'd1;
          if (e >= 3'd3) begin
            e = 3'd0;
            w_new[16*best +: 16] = {CNT_PROMOTE, fp};
            res.outcome = OC_PROMOTED;
            res.slot_index = best;
          end
        end
        w_new[48 + 4*lcell +: 4] = {e[1:0], co_inc[1:0]};
      end
    end
  end

  assign upd_go = (state == ST_UPDATE) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == AW'(BUCKETS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_MUL3;
      ST_MUL3:   state_next = ST_MUL4;
      ST_MUL4:   state_next = ST_FIN;
      ST_FIN:    state_next = ST_DIV;
      ST_DIV:    if (div_cnt == 5'd31) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (upd_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = rem[AW-1:0];
    mem_wdata = w_new;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 64'd0;
      end
      ST_UPDATE: mem_we = upd_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      bucket_count <= BUCKET_COUNT_RESET;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (cfg_valid) bucket_count <= cfg_data;
      if (upd_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item <= in_data;
        if (bucket_count == 13'd0) n_eff <= NW'(1);
        else if (bc_ext > NW'(BUCKETS)) n_eff <= NW'(BUCKETS);
        else n_eff <= bc_ext;
      end
      ST_MUL1: h <= item.flow_id * MM_C1;
      ST_MUL2: h <= k_rot * MM_C2;
      ST_MUL3: h <= h_pre * MM_F1;
      ST_MUL4: h <= h_x13 * MM_F2;
      ST_FIN: begin
        h        <= h ^ {16'd0, h[31:16]};
        dividend <= h ^ {16'd0, h[31:16]};
        rem      <= '0;
        div_cnt  <= 5'd0;
      end
      ST_DIV: begin
        // restoring remainder, one bit per cycle
        dividend <= {dividend[30:0], 1'b0};
        div_cnt  <= div_cnt + 5'd1;
        if (rem_shift >= {1'b0, n_eff}) rem <= rem_shift - {1'b0, n_eff};
        else rem <= rem_shift;
      end
      default: ;
    endcase
    if (upd_go) out_data <= res;
  end

  // bucket memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rem[AW-1:0]];
  end

endmodule
